// File: rtl/wirq_pkg.sv
// Shared types and constants for the wired interrupt controller register block.
package wirq_pkg;

    localparam int unsigned DATA_W = 32;

    typedef enum logic [1:0] {
        ACT_READ  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_EVENT = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        OUT_DONE       = 2'd0,
        OUT_REFUSED    = 2'd1,
        OUT_MISALIGNED = 2'd2
    } outcome_t;

    localparam logic [3:0] OFF_STATUS = 4'h0;
    localparam logic [3:0] OFF_MASK   = 4'h4;
    localparam logic [3:0] OFF_UNMASK = 4'h8;
    localparam logic [3:0] OFF_ACK    = 4'hc;

    localparam logic [DATA_W-1:0] ALL_ONES = '1;

    // One result word as held in the output buffer
    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        outcome_t          outcome;
        logic              irq_line;
    } result_t;

endpackage

// File: rtl/wired_irq_controller_regs_core.sv
// Top level: interrupt controller status, mask and request registers with a result buffer.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+------------------------------------------------
//  in       | in_valid / in_stall        | action, byte_offset, write_data, fill_access,
//           |                            | source_number, source_active
//  out      | out_valid / out_stall      | read_data, outcome, irq_line
//  cfg      | cfg_write_en (no wait)     | cfg_write_data (active level of the line)
//
// One word is taken per cycle while in_stall is low; its register update and result are
// formed in the same cycle. The result appears on the output in the cycle after acceptance
// when the buffer is empty, or behind any older result still held there.
// A two-entry output buffer (head plus skid) parts the channels: in_stall rises only when
// both entries hold results not yet taken.
// Reset (rst_n low, asynchronous): status 0, mask all ones, requests 0, level 0, buffer empty.
module wired_irq_controller_regs_core
    import wirq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              cfg_write_en,
    input  logic              cfg_write_data,

    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        action,
    input  logic [3:0]        byte_offset,
    input  logic [DATA_W-1:0] write_data,
    input  logic              fill_access,
    input  logic [5:0]        source_number,
    input  logic              source_active,

    output logic              out_valid,
    input  logic              out_stall,
    output logic [DATA_W-1:0] read_data,
    output logic [1:0]        outcome,
    output logic              irq_line
);

    // Architectural state
    logic [DATA_W-1:0] status_reg,    status_next;
    logic [DATA_W-1:0] mask_reg,      mask_next;
    logic [DATA_W-1:0] requested_reg, requested_next;
    logic              level_reg;

    // Output buffer: slot 0 is the head shown on the port
    result_t           slot0_reg, slot0_next;
    result_t           slot1_reg, slot1_next;
    logic [1:0]        count_reg, count_next;

    logic              in_accept;
    logic              out_take;
    result_t           result_new;

    // Event working values
    logic [DATA_W-1:0] ev_bit;
    logic [DATA_W-1:0] ev_req;
    logic [DATA_W-1:0] ev_status;

    assign in_stall  = (count_reg == 2'd2);
    assign in_accept = in_valid && !in_stall;
    assign out_valid = (count_reg != 2'd0);
    assign out_take  = out_valid && !out_stall;

    assign read_data = slot0_reg.read_data;
    assign outcome   = slot0_reg.outcome;
    assign irq_line  = slot0_reg.irq_line;

    // Event path: one-hot source bit, updated requests and recomputed status
    assign ev_bit    = DATA_W'(1) << source_number[4:0];
    assign ev_req    = source_active ? (requested_reg | ev_bit) : (requested_reg & ~ev_bit);
    assign ev_status = ev_req & ~mask_reg;

    // Word processing: register updates and the result word
    always_comb
    begin
        status_next          = status_reg;
        mask_next            = mask_reg;
        requested_next       = requested_reg;
        result_new.read_data = '0;
        result_new.outcome   = OUT_DONE;

        unique case (action)
            ACT_READ:
            begin
                if (fill_access)
                begin
                    result_new.outcome = OUT_REFUSED;
                end
                else if (byte_offset[1:0] != 2'b00)
                begin
                    result_new.outcome = OUT_MISALIGNED;
                end
                else if (byte_offset == OFF_STATUS)
                begin
                    result_new.read_data = status_reg;
                end
                else if (byte_offset == OFF_MASK)
                begin
                    result_new.read_data = mask_reg;
                end
                // unmask and ack read back zero
            end
            ACT_WRITE:
            begin
                if (fill_access)
                begin
                    result_new.outcome = OUT_REFUSED;
                end
                else if (byte_offset == OFF_MASK)
                begin
                    mask_next   = mask_reg | write_data;
                    status_next = requested_reg & ~(mask_reg | write_data);
                end
                else if (byte_offset == OFF_UNMASK)
                begin
                    mask_next   = mask_reg & ~write_data;
                    status_next = requested_reg & ~(mask_reg & ~write_data);
                end
                else if (byte_offset == OFF_ACK)
                begin
                    // requests come back in without the mask applied
                    status_next = (status_reg & ~write_data) | requested_reg;
                end
                else
                begin
                    result_new.outcome = OUT_REFUSED;
                end
            end
            ACT_EVENT:
            begin
                // sources above 31 are dropped; unchanged requests change nothing
                if (!source_number[5] && (ev_req != requested_reg))
                begin
                    requested_next = ev_req;
                    if (ev_status != status_reg)
                    begin
                        status_next = ev_status;
                        if (ev_status != '0)
                        begin
                            mask_next = mask_reg | ev_bit;
                        end
                    end
                end
            end
            default:
            begin
                // unused action code: no change, zero result
            end
        endcase

        result_new.irq_line = (status_next != '0) ? level_reg : ~level_reg;
    end

    // Output buffer control
    always_comb
    begin
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        count_next = count_reg + {1'b0, in_accept} - {1'b0, out_take};

        if (out_take)
        begin
            slot0_next = slot1_reg;
        end
        if (in_accept)
        begin
            if ((count_reg == 2'd0) || ((count_reg == 2'd1) && out_take))
            begin
                slot0_next = result_new;
            end
            else
            begin
                slot1_next = result_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg    <= '0;
            mask_reg      <= ALL_ONES;
            requested_reg <= '0;
            level_reg     <= 1'b0;
            count_reg     <= 2'd0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                level_reg <= cfg_write_data;
            end
            if (in_accept)
            begin
                status_reg    <= status_next;
                mask_reg      <= mask_next;
                requested_reg <= requested_next;
            end
            count_reg <= count_next;
        end
    end

    // Payload registers: no reset needed
    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    // Checks

    // Buffer occupancy never exceeds two entries
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("output buffer count out of range");

    // An accepted word always leaves a result on the output next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> out_valid)
        else $error("accepted word produced no result");

    // A bus read never changes the register state
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (action == ACT_READ)) |=>
            ($stable(status_reg) && $stable(mask_reg) && $stable(requested_reg)))
        else $error("read altered register state");

    // Events from sources above 31 are ignored
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (action == ACT_EVENT) && source_number[5]) |=>
            ($stable(status_reg) && $stable(mask_reg) && $stable(requested_reg)))
        else $error("out-of-range source altered state");

endmodule
